@@ sv/three_stream_event_id_aligner_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Three-stream event ID aligner: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef THREE_STREAM_EVENT_ID_ALIGNER_UNIT_DEFINES_SVH
`define THREE_STREAM_EVENT_ID_ALIGNER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSEIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSEIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tseia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner package
// Widths, codes and the record, queue head and result types shared by the aligner modules.
// ----------------------------------------------------------------------------
package tseia_pkg;

	localparam int SOURCE_COUNT = 3;
	localparam int QUEUE_DEPTH  = 2;

	localparam int SRC_W    = 2;
	localparam int ID_W     = 32;
	localparam int CNT_W    = 32;
	localparam int TRIES_W  = 16;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [SRC_W-1:0] SRC_HIGH_GAIN = 2'd0;
	localparam logic [SRC_W-1:0] SRC_LOW_GAIN  = 2'd1;
	localparam logic [SRC_W-1:0] SRC_TIME      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_COUNT      = 2'd2;

	localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EOI      = 3'd4;

	typedef struct packed {
		logic [SRC_W-1:0] source;
		logic [ID_W-1:0]  record_id;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [ID_W-1:0]         trigger_id;
		logic [CNT_W-1:0]        high_gain_index;
		logic [CNT_W-1:0]        low_gain_index;
		logic [CNT_W-1:0]        time_index;
		logic [TRIES_W-1:0]      tries;
		logic [SOURCE_COUNT-1:0] need_mask;
	} result_t;

endpackage

@@ sv/tseia_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner channel interfaces
// Record, result and register-write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface tseia_rec_if;
	logic                         valid;
	logic                         ready;
	logic [tseia_pkg::SRC_W-1:0]  source;
	logic [tseia_pkg::ID_W-1:0]   record_id;

	modport source_mp (output valid, output source, output record_id, input ready);
	modport sink (input valid, input source, input record_id, output ready);
endinterface

interface tseia_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [tseia_pkg::STATUS_W-1:0]        status;
	logic [tseia_pkg::ID_W-1:0]            trigger_id;
	logic [tseia_pkg::CNT_W-1:0]           high_gain_index;
	logic [tseia_pkg::CNT_W-1:0]           low_gain_index;
	logic [tseia_pkg::CNT_W-1:0]           time_index;
	logic [tseia_pkg::TRIES_W-1:0]         tries;
	logic [tseia_pkg::SOURCE_COUNT-1:0]    need_mask;

	modport source_mp (output valid, output status, output trigger_id,
		output high_gain_index, output low_gain_index, output time_index,
		output tries, output need_mask, input ready);
	modport sink (input valid, input status, input trigger_id,
		input high_gain_index, input low_gain_index, input time_index,
		input tries, input need_mask, output ready);
endinterface

interface tseia_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tseia_pkg::CFG_IDX_W-1:0]  index;
	logic [tseia_pkg::CNT_W-1:0]      data;

	modport source_mp (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/tseia_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner front end
// Accepts record headers, folds an all-ones ID to zero and queues them.
// ----------------------------------------------------------------------------
module tseia_front #(
	parameter int QUEUE_DEPTH = tseia_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tseia_rec_if.sink              rec,
	output tseia_pkg::queue_head_t head,
	input  logic                   pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tseia_pkg::item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	tseia_pkg::item_t in_item;
	logic             push;
	logic             do_pop;

	always_comb begin
		in_item.source    = rec.source;
		in_item.record_id = (rec.record_id == '1) ? '0 : rec.record_id;
	end

	assign rec.ready  = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push       = rec.valid && rec.ready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

@@ sv/tseia_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner back end
// Holds heads, entry counters and record counts; compares and reports.
// ----------------------------------------------------------------------------
module tseia_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tseia_pkg::queue_head_t head,
	output logic                   pop,
	tseia_cfg_if.sink              cfg,
	tseia_res_if.source_mp         res
);

	localparam int NS = tseia_pkg::SOURCE_COUNT;

	logic [tseia_pkg::CNT_W-1:0]   count_q [NS];
	logic [NS-1:0]                 head_valid_q;
	logic [tseia_pkg::ID_W-1:0]    head_id_q [NS];
	logic [tseia_pkg::CNT_W-1:0]   entry_q [NS];
	logic [tseia_pkg::TRIES_W-1:0] try_q;
	logic                          res_valid_q;
	tseia_pkg::result_t            res_q;

	logic [NS-1:0]                 hv_n;
	logic [tseia_pkg::ID_W-1:0]    hid_n [NS];
	logic [tseia_pkg::CNT_W-1:0]   ent_n [NS];
	logic [tseia_pkg::TRIES_W-1:0] try_n;
	logic [tseia_pkg::TRIES_W-1:0] try_inc;
	logic [tseia_pkg::ID_W-1:0]    mx01;
	logic [tseia_pkg::ID_W-1:0]    mx;
	logic                          eoi;
	logic                          equal;
	tseia_pkg::result_t            res_n;
	tseia_pkg::item_t              it;

	assign cfg.ready = 1'b1;
	assign it        = head.item;
	assign pop       = head.valid && (!res_valid_q || res.ready);
	assign try_inc   = (try_q == '1) ? try_q : try_q + 1'b1;

	always_comb begin
		eoi   = 1'b0;
		hv_n  = head_valid_q;
		hid_n = head_id_q;
		ent_n = entry_q;
		try_n = try_q;
		mx01  = '0;
		mx    = '0;
		equal = 1'b0;
		res_n = '0;
		res_n.status = tseia_pkg::ST_WAIT;
		for (int s = 0; s < NS; s++) begin
			if (entry_q[s] >= count_q[s]) begin
				eoi = 1'b1;
			end
		end
		if (eoi) begin
			res_n.status = tseia_pkg::ST_EOI;
		end else if (it.source >= tseia_pkg::SRC_W'(NS)) begin
			res_n.status = tseia_pkg::ST_WAIT;
		end else if (head_valid_q[it.source]) begin
			res_n.status = tseia_pkg::ST_REJECT;
		end else begin
			for (int s = 0; s < NS; s++) begin
				if (it.source == tseia_pkg::SRC_W'(s)) begin
					hv_n[s]  = 1'b1;
					hid_n[s] = it.record_id;
				end
			end
			if (&hv_n) begin
				try_n = try_inc;
				mx01  = (hid_n[1] > hid_n[0]) ? hid_n[1] : hid_n[0];
				mx    = (hid_n[2] > mx01) ? hid_n[2] : mx01;
				equal = (hid_n[0] == mx) && (hid_n[1] == mx) && (hid_n[2] == mx);
				if (equal) begin
					res_n.status          = tseia_pkg::ST_MATCH;
					res_n.trigger_id      = mx;
					res_n.high_gain_index = entry_q[0];
					res_n.low_gain_index  = entry_q[1];
					res_n.time_index      = entry_q[2];
					try_n = '0;
					hv_n  = '0;
					for (int s = 0; s < NS; s++) begin
						ent_n[s] = entry_q[s] + 1'b1;
					end
				end else begin
					res_n.status = tseia_pkg::ST_MISMATCH;
					for (int s = 0; s < NS; s++) begin
						if (hid_n[s] < mx) begin
							ent_n[s] = entry_q[s] + 1'b1;
							hv_n[s]  = 1'b0;
						end
					end
				end
			end
		end
		res_n.tries     = (res_n.status == tseia_pkg::ST_MATCH) ? try_inc : try_n;
		res_n.need_mask = ~hv_n;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) begin
				count_q[s]   <= '0;
				head_id_q[s] <= '0;
				entry_q[s]   <= '0;
			end
			head_valid_q <= '0;
			try_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					tseia_pkg::CFG_HIGH_GAIN_COUNT: begin
						count_q[0] <= cfg.data;
					end
					tseia_pkg::CFG_LOW_GAIN_COUNT: begin
						count_q[1] <= cfg.data;
					end
					tseia_pkg::CFG_TIME_COUNT: begin
						count_q[2] <= cfg.data;
					end
					default: begin
					end
				endcase
			end
			if (pop) begin
				head_valid_q <= hv_n;
				head_id_q    <= hid_n;
				entry_q      <= ent_n;
				try_q        <= try_n;
				res_valid_q  <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_q.status;
	assign res.trigger_id      = res_q.trigger_id;
	assign res.high_gain_index = res_q.high_gain_index;
	assign res.low_gain_index  = res_q.low_gain_index;
	assign res.time_index      = res_q.time_index;
	assign res.tries           = res_q.tries;
	assign res.need_mask       = res_q.need_mask;

endmodule

@@ sv/three_stream_event_id_aligner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner
// Aligns high gain, low gain and time record headers by trigger ID.
// ----------------------------------------------------------------------------
// Channels: rec takes one record header per transfer (source, record_id);
// res returns exactly one result per accepted record; cfg writes the record
// counts (index 0 high gain, 1 low gain, 2 time), always ready.
// A record accepted on rec is written into the queue, popped by the back end
// and its result registered onto res. Throughput: one record per cycle while
// res is ready, set by the combinational head compare and counter update.
// A queue of QUEUE_DEPTH records sits between the front end and the back end,
// so rec takes up to QUEUE_DEPTH more records while a result waits on res.
// When res stalls, the result register holds, the back end stops and rec
// drops ready once the queue is full; nothing is lost.
// Reset clears heads, entry counters, the try counter, the counts and the
// queue; with all counts at zero every record reports end of input.
// Program the counts while no record is in flight.
// ----------------------------------------------------------------------------
module three_stream_event_id_aligner_unit #(
	parameter int QUEUE_DEPTH = tseia_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	tseia_rec_if.sink      rec,
	tseia_res_if.source_mp res,
	tseia_cfg_if.sink      cfg
);

	tseia_pkg::queue_head_t head;
	logic                   pop;

	tseia_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec),
		.head   (head),
		.pop    (pop)
	);

	tseia_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg),
		.res    (res)
	);

endmodule

@@ sv/tseia_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner checker
// Port-level assertions on results, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_stream_event_id_aligner_unit_defines.svh"

module tseia_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic [tseia_pkg::STATUS_W-1:0]      res_status,
	input logic [tseia_pkg::ID_W-1:0]          res_trigger_id,
	input logic [tseia_pkg::CNT_W-1:0]         res_high_gain_index,
	input logic [tseia_pkg::TRIES_W-1:0]       res_tries,
	input logic [tseia_pkg::SOURCE_COUNT-1:0]  res_need_mask
);

	`TSEIA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_trigger_id), "result changed while stalled")

	`TSEIA_ASSERT_NOW(a_nomatch_zero, clk, arst_n, res_valid && res_status != tseia_pkg::ST_MATCH, res_trigger_id == '0 && res_high_gain_index == '0, "ID fields set without a match")

	`TSEIA_ASSERT_NOW(a_match_clears, clk, arst_n, res_valid && res_status == tseia_pkg::ST_MATCH, res_need_mask == '1 && res_tries != '0, "match left a head or no try")

	`TSEIA_ASSERT_NOW(a_mismatch_adv, clk, arst_n, res_valid && res_status == tseia_pkg::ST_MISMATCH, res_need_mask != '0 && res_need_mask != '1 && res_tries != '0, "mismatch advanced no head or all heads")

endmodule

bind three_stream_event_id_aligner_unit tseia_checker u_tseia_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_status          (res.status),
	.res_trigger_id      (res.trigger_id),
	.res_high_gain_index (res.high_gain_index),
	.res_tries           (res.tries),
	.res_need_mask       (res.need_mask)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stream event ID aligner testbench
// Drives record headers from the three sources, predicts the result of each
// transfer from a private copy of the heads, entry counters, try counter and
// record counts, and compares every result field with the oldest prediction.
// Covers end of input, rejects, ignored sources, all-ones IDs, try counting
// over a long mismatch run, output hold-off and random event streams.
// ----------------------------------------------------------------------------
module tb_top;
	import tseia_pkg::*;

	localparam logic [SRC_W-1:0] SRC_NONE = 2'd3;
	localparam int LIMIT_CYCLES = 600000;
	localparam logic [CFG_IDX_W-1:0] CFG_OF_SRC [SOURCE_COUNT] =
		'{CFG_HIGH_GAIN_COUNT, CFG_LOW_GAIN_COUNT, CFG_TIME_COUNT};

	logic clk;
	logic arst_n;

	tseia_rec_if rec_ch ();
	tseia_res_if res_ch ();
	tseia_cfg_if cfg_ch ();

	three_stream_event_id_aligner_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// aligner state as predicted
	logic [SOURCE_COUNT-1:0] head_ok;
	logic [ID_W-1:0]         head_trig [SOURCE_COUNT];
	logic [CNT_W-1:0]        entry_idx [SOURCE_COUNT];
	logic [CNT_W-1:0]        rec_limit [SOURCE_COUNT];
	logic [TRIES_W-1:0]      try_run;

	result_t pending_results [$];
	result_t seen_res;
	result_t want_res;

	int  mismatches;
	int  records_sent;
	int  live_records;
	int  eoi_records;
	int  matches_seen;
	int  cycles;
	int  hold_cycles;
	int  stall_left;
	bit  idle_on;
	logic [ID_W-1:0] id_base;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("three_stream_event_id_aligner_unit test failed");
			$finish;
		end
	end

	function automatic result_t predict_alignment(input logic [SRC_W-1:0] src,
		input logic [ID_W-1:0] rid);
		result_t r;
		logic done;
		logic [ID_W-1:0] top;
		int si;
		r = '0;
		done = 1'b0;
		si = src;
		for (int s = 0; s < SOURCE_COUNT; s++)
			if (entry_idx[s] >= rec_limit[s]) done = 1'b1;
		if (done) begin
			r.status = ST_EOI;
		end else if (src == SRC_NONE) begin
			r.status = ST_WAIT;
		end else if (head_ok[si]) begin
			r.status = ST_REJECT;
		end else begin
			head_trig[si] = (rid == '1) ? '0 : rid;
			head_ok[si] = 1'b1;
			if (!(&head_ok)) begin
				r.status = ST_WAIT;
			end else begin
				if (try_run != '1) try_run++;
				top = head_trig[0];
				for (int s = 1; s < SOURCE_COUNT; s++)
					if (head_trig[s] > top) top = head_trig[s];
				if (head_trig[0] == top && head_trig[1] == top && head_trig[2] == top) begin
					r.status = ST_MATCH;
					r.trigger_id = top;
					r.high_gain_index = entry_idx[SRC_HIGH_GAIN];
					r.low_gain_index = entry_idx[SRC_LOW_GAIN];
					r.time_index = entry_idx[SRC_TIME];
					r.tries = try_run;
					try_run = '0;
					for (int s = 0; s < SOURCE_COUNT; s++) begin
						entry_idx[s] = entry_idx[s] + 1'b1;
						head_ok[s] = 1'b0;
					end
				end else begin
					r.status = ST_MISMATCH;
					for (int s = 0; s < SOURCE_COUNT; s++)
						if (head_trig[s] < top) begin
							entry_idx[s] = entry_idx[s] + 1'b1;
							head_ok[s] = 1'b0;
						end
				end
			end
		end
		if (r.status != ST_MATCH) r.tries = try_run;
		r.need_mask = ~head_ok;
		return r;
	endfunction

	task automatic send_record(input logic [SRC_W-1:0] src, input logic [ID_W-1:0] rid);
		int gap;
		result_t want;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			rec_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rec_ch.valid <= 1'b1;
		rec_ch.source <= src;
		rec_ch.record_id <= rid;
		do @(posedge clk); while (!rec_ch.ready);
		want = predict_alignment(src, rid);
		pending_results.push_back(want);
		records_sent++;
		if (want.status == ST_EOI) eoi_records++;
		else if (src != SRC_NONE) live_records++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		rec_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		rec_limit[idx] = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic note_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, seen);
		end
	endtask

	// receiver: long hold-off on request, else random stall bursts
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_res.status = res_ch.status;
			seen_res.trigger_id = res_ch.trigger_id;
			seen_res.high_gain_index = res_ch.high_gain_index;
			seen_res.low_gain_index = res_ch.low_gain_index;
			seen_res.time_index = res_ch.time_index;
			seen_res.tries = res_ch.tries;
			seen_res.need_mask = res_ch.need_mask;
			if (seen_res.status == ST_MATCH) matches_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none expected, status %0d", $realtime,
						seen_res.status);
			end else begin
				want_res = pending_results.pop_front();
				note_field("status", want_res.status, seen_res.status);
				note_field("trigger_id", want_res.trigger_id, seen_res.trigger_id);
				note_field("high_gain_index", want_res.high_gain_index,
					seen_res.high_gain_index);
				note_field("low_gain_index", want_res.low_gain_index, seen_res.low_gain_index);
				note_field("time_index", want_res.time_index, seen_res.time_index);
				note_field("tries", want_res.tries, seen_res.tries);
				note_field("need_mask", want_res.need_mask, seen_res.need_mask);
			end
		end
	end

	// one trigger worth of records, mostly aligned, some with one ID shifted, duplicated or noise
	task automatic gen_event();
		int kind;
		int rot;
		int dir;
		int odd;
		logic [SRC_W-1:0] order [SOURCE_COUNT];
		logic [ID_W-1:0] id;
		id = id_base;
		id_base = id_base + $urandom_range(1, 3);
		rot = $urandom_range(0, 2);
		dir = $urandom_range(0, 1) ? 1 : 2;
		for (int k = 0; k < SOURCE_COUNT; k++)
			order[k] = SRC_W'((rot + dir * k) % SOURCE_COUNT);
		kind = $urandom_range(0, 9);
		odd = $urandom_range(0, 2);
		case (kind)
			6: begin
				for (int k = 0; k < SOURCE_COUNT; k++)
					send_record(order[k], (k == odd) ? id + $urandom_range(1, 3) : id);
			end
			7: begin
				send_record(order[0], id);
				send_record(order[0], id);
				send_record(order[1], id);
				send_record(order[2], id);
			end
			8: begin
				send_record(SRC_NONE, $urandom());
			end
			9: begin
				send_record(SRC_W'($urandom_range(0, 3)), $urandom_range(0, 1) ? '1 : $urandom());
			end
			default: begin
				for (int k = 0; k < SOURCE_COUNT; k++)
					send_record(order[k], id);
			end
		endcase
	endtask

	task automatic test_reset_end_of_input();
		send_record(SRC_HIGH_GAIN, '0);
		send_record(SRC_LOW_GAIN, '1);
		send_record(SRC_NONE, 32'd5);
		send_record(SRC_TIME, 32'h8000_0001);
		wait_idle();
	endtask

	task automatic test_directed();
		write_reg(CFG_HIGH_GAIN_COUNT, '1);
		write_reg(CFG_LOW_GAIN_COUNT, '1);
		write_reg(CFG_TIME_COUNT, '1);
		send_record(SRC_HIGH_GAIN, '0);
		send_record(SRC_TIME, '0);
		send_record(SRC_LOW_GAIN, '0);
		send_record(SRC_HIGH_GAIN, '1);
		send_record(SRC_LOW_GAIN, '0);
		send_record(SRC_TIME, '1);
		send_record(SRC_LOW_GAIN, 32'd5);
		send_record(SRC_LOW_GAIN, 32'd6);
		send_record(SRC_NONE, '1);
		send_record(SRC_HIGH_GAIN, 32'd5);
		send_record(SRC_TIME, 32'd5);
		send_record(SRC_HIGH_GAIN, 32'd10);
		send_record(SRC_LOW_GAIN, 32'hFFFF_FFFE);
		send_record(SRC_TIME, 32'd3);
		send_record(SRC_TIME, 32'hFFFF_FFFE);
		send_record(SRC_HIGH_GAIN, 32'hFFFF_FFFE);
		send_record(SRC_HIGH_GAIN, 32'd7);
		send_record(SRC_LOW_GAIN, 32'd7);
		send_record(SRC_TIME, 32'd2);
		send_record(SRC_TIME, 32'd9);
		send_record(SRC_HIGH_GAIN, 32'd9);
		send_record(SRC_LOW_GAIN, 32'd9);
		wait_idle();
	endtask

	task automatic test_tries_count();
		idle_on = 1'b0;
		send_record(SRC_HIGH_GAIN, 32'hF000_0000);
		send_record(SRC_TIME, 32'hF000_0000);
		for (int i = 1; i <= 40; i++)
			send_record(SRC_LOW_GAIN, ID_W'(i));
		send_record(SRC_LOW_GAIN, 32'hF000_0000);
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_end_of_input_limit();
		write_reg(CFG_TIME_COUNT, entry_idx[SRC_TIME] + 2);
		for (int k = 0; k < 3; k++) begin
			send_record(SRC_HIGH_GAIN, 32'h200 + k);
			send_record(SRC_LOW_GAIN, 32'h200 + k);
			send_record(SRC_TIME, 32'h200 + k);
		end
		wait_idle();
		write_reg(CFG_TIME_COUNT, '1);
		write_reg(CFG_HIGH_GAIN_COUNT, '0);
		send_record(SRC_HIGH_GAIN, 32'h300);
		send_record(SRC_NONE, 32'h300);
		wait_idle();
		write_reg(CFG_HIGH_GAIN_COUNT, '1);
	endtask

	task automatic test_output_hold_off();
		id_base = $urandom();
		hold_cycles = 48;
		for (int k = 0; k < 8; k++)
			gen_event();
		wait_idle();
	endtask

	task automatic test_random_streams();
		int live_start;
		int eoi_start;
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			for (int s = 0; s < SOURCE_COUNT; s++)
				write_reg(CFG_OF_SRC[s],
					($urandom_range(0, 2) == 0) ? entry_idx[s] + $urandom_range(30, 120) : '1);
			if (phase == 3) idle_on = 1'b0;
			id_base = $urandom();
			live_start = live_records;
			eoi_start = eoi_records;
			while (live_records - live_start < 120 && eoi_records - eoi_start < 12)
				gen_event();
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		rec_ch.valid = 1'b0;
		rec_ch.source = '0;
		rec_ch.record_id = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		head_ok = '0;
		try_run = '0;
		for (int s = 0; s < SOURCE_COUNT; s++) begin
			head_trig[s] = '0;
			entry_idx[s] = '0;
			rec_limit[s] = '0;
		end
		mismatches = 0;
		records_sent = 0;
		live_records = 0;
		eoi_records = 0;
		matches_seen = 0;
		cycles = 0;
		hold_cycles = 0;
		stall_left = 0;
		idle_on = 1'b1;
		id_base = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_end_of_input();
		test_directed();
		test_tries_count();
		test_end_of_input_limit();
		test_output_hold_off();
		test_random_streams();

		wait_idle();
		repeat (4) @(posedge clk);
		$display("Sent %0d records: %0d matched triggers, %0d end-of-input results",
			records_sent, matches_seen, eoi_records);
		$display("Covered rejects, ignored sources, long try runs, hold-off, random streams");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("three_stream_event_id_aligner_unit test passed");
		end else begin
			$display("three_stream_event_id_aligner_unit test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tseia_pkg.sv
sv/tseia_ifs.sv
sv/tseia_front.sv
sv/tseia_back.sv
sv/three_stream_event_id_aligner_unit.sv
sv/tseia_checker.sv
tb/sv/tb_top.sv
